@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dgwc_pkg.sv @@
// ----------------------------------------------------------------------------
// dgwc_pkg
// Types and constants for the discharge gap window classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package dgwc_pkg;

   localparam int unsigned TALLY_WIDTH_DEFAULT = 16;
   localparam int unsigned WINDOW_WIDTH        = 16;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd1000;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic        REG_WINDOW_LENGTH = 1'b0;

   // sense code = {not_short_bit, open_bit}
   localparam logic [1:0] CODE_OPEN    = 2'b00;
   localparam logic [1:0] CODE_INVALID = 2'b01;
   localparam logic [1:0] CODE_ARC     = 2'b10;
   localparam logic [1:0] CODE_SHORT   = 2'b11;

   typedef enum logic [1:0] {
      CLASS_OPEN  = 2'd0,
      CLASS_ARC   = 2'd1,
      CLASS_SHORT = 2'd2
   } class_type;

   typedef struct packed {
      logic not_short_bit;
      logic open_bit;
   } sample_type;

   typedef struct packed {
      class_type gap_state;
      logic      window_done;
      logic      invalid_sample;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/dgwc_sample_reg.sv @@
// ----------------------------------------------------------------------------
// dgwc_sample_reg
// Input register stage for sense samples with pass-through flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module dgwc_sample_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire dgwc_pkg::sample_type in_sample,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output dgwc_pkg::sample_type     out_sample
);
   import dgwc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   sample_type sample_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sample_ff <= in_sample;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

endmodule

`default_nettype wire

@@ hdl/dgwc_window_core.sv @@
// ----------------------------------------------------------------------------
// dgwc_window_core
// Window tallies, class decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dgwc_window_core #(
   parameter int unsigned TALLY_WIDTH = dgwc_pkg::TALLY_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [dgwc_pkg::WINDOW_WIDTH-1:0]    window_length,
   input  wire logic                                 s_valid,
   output logic                                      s_ready,
   input  wire dgwc_pkg::sample_type                 s_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output dgwc_pkg::result_type                      rsp_result
);
   import dgwc_pkg::*;

   localparam logic [TALLY_WIDTH-1:0] TALLY_ONE = TALLY_WIDTH'(1);

   logic [WINDOW_WIDTH-1:0] tick_count_ff,  tick_count_in;
   logic [TALLY_WIDTH-1:0]  open_tally_ff,  open_tally_in;
   logic [TALLY_WIDTH-1:0]  arc_tally_ff,   arc_tally_in;
   logic [TALLY_WIDTH-1:0]  short_tally_ff, short_tally_in;
   class_type               class_ff,       class_in;
   logic                    valid_ff,       valid_in;
   result_type              result_ff,      result_in;

   logic [1:0]              code;
   logic [WINDOW_WIDTH-1:0] tick_next;
   logic [TALLY_WIDTH-1:0]  open_next, arc_next, short_next;
   logic                    invalid;
   logic                    close;
   logic                    advance;

   assign s_ready = !valid_ff || rsp_ready;
   assign advance = s_valid && s_ready;
   assign code    = {s_sample.not_short_bit, s_sample.open_bit};

   always_comb begin
      open_next  = open_tally_ff;
      arc_next   = arc_tally_ff;
      short_next = short_tally_ff;
      invalid    = 1'b0;
      case (code)
         CODE_OPEN: begin
            if (open_tally_ff != '1) open_next = open_tally_ff + TALLY_ONE;
         end
         CODE_ARC: begin
            if (arc_tally_ff != '1) arc_next = arc_tally_ff + TALLY_ONE;
         end
         CODE_SHORT: begin
            if (short_tally_ff != '1) short_next = short_tally_ff + TALLY_ONE;
         end
         default: begin
            invalid = 1'b1;
         end
      endcase

      tick_next = tick_count_ff + WINDOW_WIDTH'(1);
      close     = (tick_next >= window_length);

      tick_count_in  = tick_next;
      open_tally_in  = open_next;
      arc_tally_in   = arc_next;
      short_tally_in = short_next;
      class_in       = class_ff;
      if (close) begin
         // ties: arc, then short, then open
         if (arc_next >= open_next && arc_next >= short_next) begin
            class_in = CLASS_ARC;
         end else if (short_next >= open_next) begin
            class_in = CLASS_SHORT;
         end else begin
            class_in = CLASS_OPEN;
         end
         tick_count_in  = '0;
         open_tally_in  = '0;
         arc_tally_in   = '0;
         short_tally_in = '0;
      end

      result_in.gap_state      = class_in;
      result_in.window_done    = close;
      result_in.invalid_sample = invalid;

      valid_in = valid_ff && !rsp_ready;
      if (advance) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         open_tally_ff  <= '0;
         arc_tally_ff   <= '0;
         short_tally_ff <= '0;
         class_ff       <= CLASS_OPEN;
         valid_ff       <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            tick_count_ff  <= tick_count_in;
            open_tally_ff  <= open_tally_in;
            arc_tally_ff   <= arc_tally_in;
            short_tally_ff <= short_tally_in;
            class_ff       <= class_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

@@ hdl/discharge_gap_window_classifier.sv @@
// ----------------------------------------------------------------------------
// discharge_gap_window_classifier
// Classifies discharge gap sense samples over a programmable tick window.
//
// req_*: one sense sample per transfer, tdata[0] open_bit, tdata[1]
//   not_short_bit. rsp_*: one result per sample, tdata[1:0] gap_state,
//   tlast window_done, tuser invalid_sample.
// csr_*: APB-style port, window_length at byte address 0, pready always high.
//   Write only while the stream is idle.
// Path: a transferred sample passes the input register, then the
//   tally/decision logic into the result register, before its result
//   is offered on rsp_*.
// Throughput: one sample per cycle while rsp_tready stays high; tally
//   update and three-way compare are combinational.
// Reset: tallies, tick count and both stage valids clear, state goes to open,
//   window_length returns to 1000.
// Stall: while rsp_tready is low the result register holds; one more sample
//   fills the input register, then req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module discharge_gap_window_classifier #(
   parameter int unsigned TALLY_WIDTH = dgwc_pkg::TALLY_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,   // open_bit, not_short_bit
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [7:0]                                rsp_tdata,   // gap_state[1:0]
   output logic                                      rsp_tlast,   // window_done
   output logic                                      rsp_tuser,   // invalid_sample
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [dgwc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [dgwc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dgwc_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                                      csr_pready
);
   import dgwc_pkg::*;

   logic [WINDOW_WIDTH-1:0] window_length_ff;
   logic                    csr_index;
   logic                    csr_write;
   sample_type              req_sample;
   sample_type              s_sample;
   logic                    s_valid;
   logic                    s_ready;
   result_type              result;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else if (csr_write && csr_index == REG_WINDOW_LENGTH) begin
         window_length_ff <= csr_pwdata[WINDOW_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_WINDOW_LENGTH) begin
         csr_prdata = CSR_DATA_WIDTH'(window_length_ff);
      end
   end

   assign req_sample.open_bit      = req_tdata[0];
   assign req_sample.not_short_bit = req_tdata[1];

   dgwc_sample_reg u_sample_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_sample),
      .out_valid  (s_valid),
      .out_ready  (s_ready),
      .out_sample (s_sample)
   );

   dgwc_window_core #(
      .TALLY_WIDTH (TALLY_WIDTH)
   ) u_window_core (
      .clock         (clock),
      .reset         (reset),
      .window_length (window_length_ff),
      .s_valid       (s_valid),
      .s_ready       (s_ready),
      .s_sample      (s_sample),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_result    (result)
   );

   assign rsp_tdata = {6'b0, result.gap_state};
   assign rsp_tlast = result.window_done;
   assign rsp_tuser = result.invalid_sample;

endmodule

`default_nettype wire

@@ hdl/dgwc_checker.sv @@
// ----------------------------------------------------------------------------
// dgwc_checker
// Port-level checks for the discharge gap window classifier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dgwc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   logic       rsp_xfer;
   logic       rsp_stall;
   logic [9:0] rsp_bundle;
   logic [1:0] last_gap_ff, last_gap_in;

   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_bundle = {rsp_tuser, rsp_tlast, rsp_tdata};

   always_comb begin
      last_gap_in = last_gap_ff;
      if (rsp_xfer) begin
         last_gap_in = rsp_tdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_gap_ff <= 2'd0;
      end else begin
         last_gap_ff <= last_gap_in;
      end
   end

   property p_rsp_hold;
      rsp_stall |=> rsp_tvalid && $stable(rsp_bundle);
   endproperty

   property p_rsp_code;
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[7:2] == 6'd0;
   endproperty

   property p_reset_clear;
      reset |=> !rsp_tvalid;
   endproperty

   property p_state_hold;
      rsp_xfer && !rsp_tlast |-> rsp_tdata[1:0] == last_gap_ff;
   endproperty

   `ASSERT_CLK(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result changed")
   `ASSERT_CLK(a_rsp_code, clock, reset, p_rsp_code, "bad gap state encoding")
   `ASSERT_CLK_ALWAYS(a_reset_clear, clock, p_reset_clear, "result valid after reset")
   `ASSERT_CLK(a_state_hold, clock, reset, p_state_hold, "gap state moved without window close")

endmodule

bind discharge_gap_window_classifier dgwc_checker u_dgwc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the discharge gap window classifier: a directed
// table of sense samples with expected results, then random windows and sample
// mixes with bursty sending and patterned result stalls, checked against a
// cycle-free model of the window tallies and the arc/short/open decision.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dgwc_pkg::*;

   localparam int unsigned TW           = TALLY_WIDTH_DEFAULT;
   localparam int          REG_UNUSED   = 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_WINDOW =
      CSR_ADDR_WIDTH'(4 * REG_WINDOW_LENGTH);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNUSED = CSR_ADDR_WIDTH'(4 * REG_UNUSED);
   localparam int          RANDOM_ITEMS = 750;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          STUCK_LIMIT  = 500;

   typedef struct packed {
      bit                     set_win;
      bit                     poke_unused;
      logic [WINDOW_WIDTH-1:0] win;
      logic [1:0]             code;
      bit                     typed;
      result_type             want;
   } step_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;      // open_bit, not_short_bit
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;           // gap_state[1:0]
   logic                      rsp_tlast;           // window_done
   logic                      rsp_tuser;           // invalid_sample
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   discharge_gap_window_classifier u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // classifier model state
   logic [WINDOW_WIDTH-1:0] win_len;
   logic [WINDOW_WIDTH-1:0] ticks;
   logic [TW-1:0]           open_cnt;
   logic [TW-1:0]           arc_cnt;
   logic [TW-1:0]           short_cnt;
   class_type               latched_class;

   result_type  pending_results [$];
   int unsigned mismatches = 0;
   logic [1:0]  sense_codes [4] = '{CODE_OPEN, CODE_INVALID, CODE_ARC, CODE_SHORT};

   function automatic logic [TW-1:0] tally_bump(input logic [TW-1:0] t);
      return (&t) ? t : t + 1'b1;
   endfunction

   function automatic void classifier_reset();
      win_len       = WINDOW_RESET;
      ticks         = '0;
      open_cnt      = '0;
      arc_cnt       = '0;
      short_cnt     = '0;
      latched_class = CLASS_OPEN;
   endfunction

   function automatic void classifier_config(input int index, input logic [31:0] value);
      if (index == REG_WINDOW_LENGTH) win_len = value[WINDOW_WIDTH-1:0];
   endfunction

   function automatic result_type classify_tick(input logic [1:0] code);
      result_type r;
      logic [TW-1:0] top;
      r = '0;
      case (code)
         CODE_OPEN:  open_cnt  = tally_bump(open_cnt);
         CODE_ARC:   arc_cnt   = tally_bump(arc_cnt);
         CODE_SHORT: short_cnt = tally_bump(short_cnt);
         default:    r.invalid_sample = 1'b1;
      endcase
      ticks = ticks + 1'b1;
      if (ticks >= win_len) begin
         top = (open_cnt > arc_cnt) ? open_cnt : arc_cnt;
         if (short_cnt > top) top = short_cnt;
         if (top == arc_cnt)        latched_class = CLASS_ARC;
         else if (top == short_cnt) latched_class = CLASS_SHORT;
         else                       latched_class = CLASS_OPEN;
         ticks     = '0;
         open_cnt  = '0;
         arc_cnt   = '0;
         short_cnt = '0;
         r.window_done = 1'b1;
      end
      r.gap_state = latched_class;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // result checker
   result_type want_now;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer, gap_state", int'(rsp_tdata), -1);
         end else begin
            want_now = pending_results.pop_front();
            if (rsp_tdata != {6'b0, want_now.gap_state})
               report_mismatch("gap_state", int'(rsp_tdata), int'(want_now.gap_state));
            if (rsp_tlast != want_now.window_done)
               report_mismatch("window_done", int'(rsp_tlast), int'(want_now.window_done));
            if (rsp_tuser != want_now.invalid_sample)
               report_mismatch("invalid_sample", int'(rsp_tuser),
                               int'(want_now.invalid_sample));
         end
      end
   end

   // receiver stall pattern, re-picked every epoch
   int unsigned rx_epoch = 0, rx_cycle = 0, rx_period = 1, rx_duty = 1;
   always @(negedge clock) begin
      if (rx_epoch == 0) begin
         rx_epoch  = $urandom_range(16, 200);
         rx_period = $urandom_range(1, 8);
         rx_duty   = $urandom_range(1, rx_period);
         rx_cycle  = 0;
      end
      rx_epoch--;
      rsp_tready <= (rx_cycle % rx_period) < rx_duty;
      rx_cycle++;
   end

   // watchdog
   int unsigned stuck_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("TIMEOUT: no transfer for %0d cycles", STUCK_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_sample(input logic [1:0] code, input bit typed, input result_type want);
      result_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, code};
      do @(posedge clock); while (!req_tready);
      predicted = classify_tick(code);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic idle_cycles(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic settle();
      idle_cycles(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic [CSR_ADDR_WIDTH-1:0] addr, input bit wr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window(input logic [WINDOW_WIDTH-1:0] value);
      logic [31:0] rd;
      csr_access(ADDR_WINDOW, 1'b1, {16'b0, value}, rd);
      classifier_config(int'(REG_WINDOW_LENGTH), {16'b0, value});
      csr_access(ADDR_WINDOW, 1'b0, '0, rd);
      if (rd != {16'b0, win_len})
         report_mismatch("window_length readback", int'(rd), int'(win_len));
   endtask

   // set_win, poke_unused, win, code, typed, want{gap_state, window_done, invalid}
   step_row_type directed_steps [23] = '{
      '{1'b1, 1'b0, 16'd0,     CODE_OPEN,    1'b1, '{CLASS_OPEN,  1'b1, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_ARC,     1'b1, '{CLASS_ARC,   1'b1, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_SHORT,   1'b1, '{CLASS_SHORT, 1'b1, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_INVALID, 1'b1, '{CLASS_ARC,   1'b1, 1'b1}},
      '{1'b1, 1'b0, 16'd1,     CODE_SHORT,   1'b1, '{CLASS_SHORT, 1'b1, 1'b0}},
      '{1'b1, 1'b0, 16'd3,     CODE_OPEN,    1'b1, '{CLASS_SHORT, 1'b0, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_OPEN,    1'b1, '{CLASS_SHORT, 1'b0, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_SHORT,   1'b1, '{CLASS_OPEN,  1'b1, 1'b0}},
      // arc/short tie
      '{1'b0, 1'b0, 16'd0,     CODE_ARC,     1'b1, '{CLASS_OPEN,  1'b0, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_SHORT,   1'b1, '{CLASS_OPEN,  1'b0, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_INVALID, 1'b1, '{CLASS_ARC,   1'b1, 1'b1}},
      // short/open tie
      '{1'b0, 1'b0, 16'd0,     CODE_SHORT,   1'b1, '{CLASS_ARC,   1'b0, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_OPEN,    1'b1, '{CLASS_ARC,   1'b0, 1'b0}},
      '{1'b0, 1'b0, 16'd0,     CODE_INVALID, 1'b1, '{CLASS_SHORT, 1'b1, 1'b1}},
      // write to unused register must leave the window at 3
      '{1'b0, 1'b1, 16'd0,     CODE_INVALID, 1'b1, '{CLASS_SHORT, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 16'd0,     CODE_INVALID, 1'b1, '{CLASS_SHORT, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 16'd0,     CODE_INVALID, 1'b1, '{CLASS_ARC,   1'b1, 1'b1}},
      // max window, then shorten below the running count
      '{1'b1, 1'b0, 16'hFFFF,  CODE_OPEN,    1'b0, '0},
      '{1'b0, 1'b0, 16'd0,     CODE_OPEN,    1'b0, '0},
      '{1'b0, 1'b0, 16'd0,     CODE_OPEN,    1'b0, '0},
      '{1'b0, 1'b0, 16'd0,     CODE_SHORT,   1'b0, '0},
      '{1'b1, 1'b0, 16'd2,     CODE_SHORT,   1'b0, '0},
      '{1'b0, 1'b0, 16'd0,     CODE_ARC,     1'b0, '0}
   };

   initial begin
      logic [31:0]             rd;
      logic [WINDOW_WIDTH-1:0] phase_win;
      logic [1:0]              favored, code;
      int unsigned             sent, phase_len, bias, burst;
      bit                      gappy;

      classifier_reset();
      sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(ADDR_WINDOW, 1'b0, '0, rd);
      if (rd != {16'b0, WINDOW_RESET})
         report_mismatch("window_length reset", int'(rd), int'(WINDOW_RESET));

      foreach (directed_steps[i]) begin
         if (directed_steps[i].set_win) begin
            settle();
            set_window(directed_steps[i].win);
         end
         if (directed_steps[i].poke_unused) begin
            settle();
            csr_access(ADDR_UNUSED, 1'b1, 32'd1, rd);
            classifier_config(REG_UNUSED, 32'd1);
         end
         send_sample(directed_steps[i].code, directed_steps[i].typed, directed_steps[i].want);
      end

      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 11))
            0:       phase_win = '0;
            1:       phase_win = 16'd1;
            2:       phase_win = 16'hFFFF;
            3:       phase_win = WINDOW_WIDTH'($urandom_range(17, 200));
            4:       phase_win = WINDOW_WIDTH'($urandom_range(1000, 65534));
            default: phase_win = WINDOW_WIDTH'($urandom_range(2, 12));
         endcase
         settle();
         set_window(phase_win);
         phase_len = $urandom_range(20, 120);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         favored   = sense_codes[$urandom_range(0, 3)];
         bias      = $urandom_range(0, 90);
         gappy     = $urandom_range(0, 3) != 0;
         burst     = $urandom_range(1, 20);
         repeat (phase_len) begin
            if (gappy && burst == 0) begin
               idle_cycles($urandom_range(1, 8));
               burst = $urandom_range(1, 20);
            end
            code = ($urandom_range(0, 99) < bias) ? favored : sense_codes[$urandom_range(0, 3)];
            send_sample(code, 1'b0, '0);
            if (burst != 0) burst--;
            sent++;
         end
      end

      idle_cycles(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 0, pending_results.size());

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/dgwc_pkg.sv
hdl/dgwc_sample_reg.sv
hdl/dgwc_window_core.sv
hdl/discharge_gap_window_classifier.sv
hdl/dgwc_checker.sv
tb/tb_top.sv
